### design/bf16_matrix_vector_multiply_assert.svh
// Assertion macros shared by the bf16 matrix-vector multiply RTL.
`ifndef BF16_MATRIX_VECTOR_MULTIPLY_ASSERT_SVH
`define BF16_MATRIX_VECTOR_MULTIPLY_ASSERT_SVH

// Condition must never hold while out of reset.
`define BMV_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

// Antecedent implies consequent in the same cycle.
`define BMV_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the next cycle.
`define BMV_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/bmv_pkg.sv
// Package for the bf16 matrix-vector multiply: types, constants, fp32 helpers.
`default_nettype none

package bmv_pkg;

    // Sizes fixed by the item fields
    localparam int BF16_W       = 16;
    localparam int RESULT_ROW_W = 10;
    localparam int ROW_COUNT_W  = 11;
    localparam int COL_W        = 16;
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 16;
    localparam int MAX_ROWS_DEF = 1024;

    // Queue depths
    localparam int ITEM_Q_DEPTH = 4;
    localparam int OUT_DEPTH    = 16;

    // Unpacked fp working format
    localparam int EXP_W  = 12;
    localparam int MANT_W = 50;

    // Reset values of the configuration registers
    localparam logic [ROW_COUNT_W-1:0] ROW_COUNT_RST = 11'd1;
    localparam logic [COL_W-1:0]       COL_COUNT_RST = 16'd1;
    localparam logic [BF16_W-1:0]      ALPHA_RST     = 16'h3F80;
    localparam logic [BF16_W-1:0]      BETA_RST      = 16'h0000;

    // fp32 constants
    localparam logic [31:0] F32_QNAN = 32'h7FC0_0000;
    localparam logic [31:0] F32_ZERO = 32'h0000_0000;
    localparam logic [15:0] BF16_QNAN = 16'h7FC0;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_ROW_COUNT = 2'd0,
        CFG_COL_COUNT = 2'd1,
        CFG_ALPHA     = 2'd2,
        CFG_BETA      = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [BF16_W-1:0] matrix_elem;
        logic [BF16_W-1:0] vector_elem;
        logic [BF16_W-1:0] old_result;
    } in_item_t;

    typedef struct packed {
        logic [BF16_W-1:0]       new_result;
        logic [RESULT_ROW_W-1:0] result_row;
        logic                    final_row;
    } out_item_t;

    // Classification of an item made by the front end
    typedef struct packed {
        logic col0;
        logic last_col;
        logic last_row;
    } item_cls_t;

    // Scale factors handed to the back end
    typedef struct packed {
        logic [BF16_W-1:0] alpha;
        logic [BF16_W-1:0] beta;
    } scale_t;

    typedef enum logic [1:0] {
        FP_NUM,
        FP_ZERO,
        FP_INF,
        FP_NAN
    } fp_class_t;

    // Value = mant / 2^(MANT_W-1) * 2^(exp - 127), or a special class
    typedef struct packed {
        logic                    sign;
        fp_class_t               cls;
        logic signed [EXP_W-1:0] exp;
        logic [MANT_W-1:0]       mant;
    } fp_raw_t;

    function automatic logic f32_is_nan(logic [31:0] a);
        return (&a[30:23]) && (|a[22:0]);
    endfunction

    function automatic logic f32_is_inf(logic [31:0] a);
        return (&a[30:23]) && !(|a[22:0]);
    endfunction

    // Exact product of two fp32 values, unrounded
    function automatic fp_raw_t fp_mul_raw(logic [31:0] a, logic [31:0] b);
        fp_raw_t    r;
        logic [23:0] ma;
        logic [23:0] mb;
        logic [9:0]  ea;
        logic [9:0]  eb;
        logic        a_zero;
        logic        b_zero;
        logic        a_inf;
        logic        b_inf;
        ma = {|a[30:23], a[22:0]};
        mb = {|b[30:23], b[22:0]};
        ea = (a[30:23] == 8'd0) ? 10'd1 : {2'b00, a[30:23]};
        eb = (b[30:23] == 8'd0) ? 10'd1 : {2'b00, b[30:23]};
        a_zero = (a[30:0] == 31'd0);
        b_zero = (b[30:0] == 31'd0);
        a_inf = f32_is_inf(a);
        b_inf = f32_is_inf(b);
        r.sign = a[31] ^ b[31];
        r.mant = {2'b00, 48'(ma) * 48'(mb)};
        r.exp  = $signed({2'b00, ea}) + $signed({2'b00, eb}) - 12'sd124;
        if (f32_is_nan(a) || f32_is_nan(b) || (a_inf && b_zero) || (b_inf && a_zero))
        begin
            r.cls = FP_NAN;
        end
        else if (a_inf || b_inf)
        begin
            r.cls = FP_INF;
        end
        else if (a_zero || b_zero)
        begin
            r.cls = FP_ZERO;
        end
        else
        begin
            r.cls = FP_NUM;
        end
        return r;
    endfunction

    // Exact sum of two fp32 values up to a sticky bit, unrounded
    function automatic fp_raw_t fp_add_raw(logic [31:0] a, logic [31:0] b);
        fp_raw_t     r;
        logic [31:0] x;
        logic [31:0] y;
        logic [23:0] mx;
        logic [23:0] my;
        logic [7:0]  ex;
        logic [7:0]  ey;
        logic [7:0]  d;
        logic [5:0]  dc;
        logic [49:0] al_x;
        logic [99:0] sh;
        logic [49:0] al_y;
        logic [49:0] s;
        x = (a[30:0] >= b[30:0]) ? a : b;
        y = (a[30:0] >= b[30:0]) ? b : a;
        mx = {|x[30:23], x[22:0]};
        my = {|y[30:23], y[22:0]};
        ex = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
        ey = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
        d  = ex - ey;
        dc = (d > 8'd50) ? 6'd50 : d[5:0];
        al_x = {1'b0, mx, 25'd0};
        sh   = {1'b0, my, 25'd0, 50'd0} >> dc;
        al_y = sh[99:50] | {49'd0, |sh[49:0]};
        s = (x[31] ^ y[31]) ? (al_x - al_y) : (al_x + al_y);
        r.sign = x[31];
        r.mant = s;
        r.exp  = $signed({4'b0000, ex}) + 12'sd1;
        if (f32_is_nan(a) || f32_is_nan(b) ||
            (f32_is_inf(a) && f32_is_inf(b) && (a[31] != b[31])))
        begin
            r.cls = FP_NAN;
        end
        else if (f32_is_inf(a) || f32_is_inf(b))
        begin
            r.cls  = FP_INF;
            r.sign = f32_is_inf(a) ? a[31] : b[31];
        end
        else if (s == 50'd0)
        begin
            // exact zero: -0 only when both inputs are -0
            r.cls  = FP_ZERO;
            r.sign = a[31] & b[31];
        end
        else
        begin
            r.cls = FP_NUM;
        end
        return r;
    endfunction

    // Move the leading one to the top bit
    function automatic fp_raw_t fp_norm(fp_raw_t r);
        fp_raw_t    n;
        logic [5:0] lz;
        n  = r;
        lz = 6'd0;
        for (int i = 0; i < MANT_W; i++)
        begin
            if (r.mant[i])
            begin
                lz = 6'(MANT_W - 1 - i);
            end
        end
        if (r.cls == FP_NUM)
        begin
            n.mant = r.mant << lz;
            n.exp  = r.exp - $signed({6'd0, lz});
        end
        return n;
    endfunction

    // Round a normalized value to fp32, nearest even, subnormals kept
    function automatic logic [31:0] fp_round(fp_raw_t r);
        logic [31:0]             res;
        logic [49:0]             m;
        logic [99:0]             sh;
        logic signed [EXP_W-1:0] rs;
        logic [5:0]              rsc;
        logic [7:0]              ef;
        logic                    xs;
        logic [30:0]             body;
        logic                    up;
        m    = r.mant;
        sh   = 100'd0;
        rs   = 12'sd1 - r.exp;
        rsc  = 6'd0;
        ef   = r.exp[7:0];
        xs   = 1'b0;
        body = 31'd0;
        up   = 1'b0;
        res  = F32_QNAN;
        unique case (r.cls)
            FP_NAN:  res = F32_QNAN;
            FP_INF:  res = {r.sign, 8'hFF, 23'd0};
            FP_ZERO: res = {r.sign, 31'd0};
            FP_NUM:
            begin
                if (r.exp >= 12'sd255)
                begin
                    res = {r.sign, 8'hFF, 23'd0};
                end
                else
                begin
                    if (r.exp < 12'sd1)
                    begin
                        // subnormal: shift right into the fixed exponent
                        rsc = (rs > 12'sd50) ? 6'd50 : rs[5:0];
                        sh  = {r.mant, 50'd0} >> rsc;
                        m   = sh[99:50];
                        xs  = |sh[49:0];
                        ef  = 8'd0;
                    end
                    body = {ef, m[48:26]};
                    up   = m[25] & ((|m[24:0]) | xs | body[0]);
                    res  = {r.sign, body + {30'd0, up}};
                end
            end
        endcase
        return res;
    endfunction

    // fp32 to bf16, nearest even, one quiet NaN
    function automatic logic [BF16_W-1:0] f32_to_bf16(logic [31:0] w);
        logic [31:0] t;
        t = w + 32'h0000_7FFF + {31'd0, w[16]};
        return f32_is_nan(w) ? BF16_QNAN : t[31:16];
    endfunction

endpackage

`default_nettype wire

### design/bmv_fifo.sv
// Small register queue between pipeline parts.
`default_nettype none

module bmv_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             valid,
    output logic [WIDTH-1:0] data
);

    `include "bf16_matrix_vector_multiply_assert.svh"

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;

    // Pointer and fill updates
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign full  = (count_reg == CW'(DEPTH));
    assign valid = (count_reg != '0);
    assign data  = mem_reg[rd_ptr_reg];

    `BMV_ASSERT_NEVER(a_no_overflow, push && full && !pop, "queue written while full")
    `BMV_ASSERT_NEXT(a_pop_drains, pop && !push && (count_reg == CW'(1)), !valid,
        "queue not empty after last item taken")

endmodule

`default_nettype wire

### design/bmv_front.sv
// Front end: configuration registers, row/column tracking and item classification.
`default_nettype none

module bmv_front #(
    parameter int MAX_ROWS = bmv_pkg::MAX_ROWS_DEF,
    parameter int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
    parameter int QW = $bits(bmv_pkg::in_item_t) + RW + $bits(bmv_pkg::item_cls_t)
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              wr_en,
    input  logic [bmv_pkg::CFG_INDEX_W-1:0]   wr_index,
    input  logic [bmv_pkg::CFG_DATA_W-1:0]    wr_data,
    input  logic                              item_valid,
    output logic                              item_ready,
    input  bmv_pkg::in_item_t                 item,
    output logic                              q_push,
    output logic [QW-1:0]                     q_data,
    input  logic                              q_full,
    output bmv_pkg::scale_t                   scale
);

    import bmv_pkg::*;

    localparam int RCW   = $clog2(MAX_ROWS + 1);
    localparam int CMP_W = ((RCW > ROW_COUNT_W) ? RCW : ROW_COUNT_W) + 1;

    logic [ROW_COUNT_W-1:0] row_count_reg;
    logic [COL_W-1:0]       col_count_reg;
    logic [BF16_W-1:0]      alpha_reg;
    logic [BF16_W-1:0]      beta_reg;
    logic [RW-1:0]          row_pos_reg, row_pos_next;
    logic [COL_W-1:0]       col_pos_reg, col_pos_next;

    logic [CMP_W-1:0] rows_eff;
    logic [COL_W:0]   cols_eff;
    item_cls_t        cls;
    logic             accept;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg <= ROW_COUNT_RST;
            col_count_reg <= COL_COUNT_RST;
            alpha_reg     <= ALPHA_RST;
            beta_reg      <= BETA_RST;
        end
        else if (wr_en)
        begin
            unique case (cfg_reg_t'(wr_index))
                CFG_ROW_COUNT: row_count_reg <= wr_data[ROW_COUNT_W-1:0];
                CFG_COL_COUNT: col_count_reg <= wr_data[COL_W-1:0];
                CFG_ALPHA:     alpha_reg     <= wr_data[BF16_W-1:0];
                CFG_BETA:      beta_reg      <= wr_data[BF16_W-1:0];
            endcase
        end
    end

    // Effective counts: zero acts as one, rows capped at storage depth
    always_comb
    begin
        rows_eff = (row_count_reg == '0) ? CMP_W'(1) : CMP_W'(row_count_reg);
        if (rows_eff > CMP_W'(MAX_ROWS))
        begin
            rows_eff = CMP_W'(MAX_ROWS);
        end
        cols_eff = (col_count_reg == '0) ? 17'd1 : {1'b0, col_count_reg};
    end

    // Classify the current item; a position past the end counts as the last
    always_comb
    begin
        cls.col0     = (col_pos_reg == '0);
        cls.last_col = ({1'b0, col_pos_reg} + 17'd1) >= cols_eff;
        cls.last_row = (CMP_W'(row_pos_reg) + CMP_W'(1)) >= rows_eff;
    end

    assign item_ready = !q_full;
    assign accept     = item_valid && item_ready;
    assign q_push     = accept;
    assign q_data     = {item, row_pos_reg, cls};
    assign scale      = '{alpha: alpha_reg, beta: beta_reg};

    // Position stepping, column-major
    always_comb
    begin
        row_pos_next = row_pos_reg;
        col_pos_next = col_pos_reg;
        if (accept)
        begin
            if (cls.last_row)
            begin
                row_pos_next = '0;
                col_pos_next = cls.last_col ? '0 : col_pos_reg + 1'b1;
            end
            else
            begin
                row_pos_next = row_pos_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_pos_reg <= '0;
            col_pos_reg <= '0;
        end
        else
        begin
            row_pos_reg <= row_pos_next;
            col_pos_reg <= col_pos_next;
        end
    end

endmodule

`default_nettype wire

### design/bmv_back.sv
// Back end: multiply-accumulate pipeline with row-sum memory and scaling tail.
`default_nettype none

module bmv_back #(
    parameter int MAX_ROWS = bmv_pkg::MAX_ROWS_DEF,
    parameter int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
    parameter int QW = $bits(bmv_pkg::in_item_t) + RW + $bits(bmv_pkg::item_cls_t)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               head_valid,
    input  logic [QW-1:0]      head_data,
    output logic               head_pop,
    input  bmv_pkg::scale_t    scale,
    output logic               push,
    output bmv_pkg::out_item_t push_item,
    input  logic               result_taken
);

    import bmv_pkg::*;

    `include "bf16_matrix_vector_multiply_assert.svh"

    localparam int CNT_W = $clog2(OUT_DEPTH + 1);

    in_item_t  h_item;
    logic [RW-1:0] h_row;
    item_cls_t h_cls;
    logic      hit;
    logic      issue;

    // Row sums, undefined until written
    logic [31:0] sums_mem [MAX_ROWS];
    logic [31:0] rd_data_reg;

    // Accumulate pipeline: multiply (1-3), add (4-6)
    logic          s1_v_reg, s2_v_reg, s3_v_reg, s4_v_reg, s5_v_reg, s6_v_reg;
    logic [RW-1:0] s1_row_reg, s2_row_reg, s3_row_reg, s4_row_reg, s5_row_reg, s6_row_reg;
    item_cls_t     s1_cls_reg, s2_cls_reg, s3_cls_reg, s4_cls_reg, s5_cls_reg, s6_cls_reg;
    logic [BF16_W-1:0] s1_old_reg, s2_old_reg, s3_old_reg, s4_old_reg, s5_old_reg, s6_old_reg;
    fp_raw_t       s1_raw_reg, s2_raw_reg, s4_raw_reg, s5_raw_reg;
    logic [31:0]   s3_prod_reg, s6_acc_reg;

    // Scaling tail: alpha and beta products (7-9), final add (10-12)
    logic          s7_v_reg, s8_v_reg, s9_v_reg, s10_v_reg, s11_v_reg, s12_v_reg;
    logic [RW-1:0] s7_row_reg, s8_row_reg, s9_row_reg, s10_row_reg, s11_row_reg, s12_row_reg;
    logic          s7_last_reg, s8_last_reg, s9_last_reg;
    logic          s10_last_reg, s11_last_reg, s12_last_reg;
    logic          s7_bnz_reg, s8_bnz_reg, s9_bnz_reg, s10_bnz_reg, s11_bnz_reg, s12_bnz_reg;
    fp_raw_t       s7_a_reg, s8_a_reg, s7_b_reg, s8_b_reg;
    logic [31:0]   s9_t_reg, s9_by_reg, s10_t_reg, s11_t_reg, s12_t_reg;
    fp_raw_t       s10_raw_reg, s11_raw_reg, s12_raw_reg;

    logic [CNT_W-1:0] out_count_reg, out_count_next;
    logic [31:0]      final_f32;

    assign {h_item, h_row, h_cls} = head_data;

    // Read-after-write guard: the sum for a row must be written before it is read
    assign hit = (s1_v_reg && (s1_row_reg == h_row)) || (s2_v_reg && (s2_row_reg == h_row)) ||
                 (s3_v_reg && (s3_row_reg == h_row)) || (s4_v_reg && (s4_row_reg == h_row));

    assign issue = head_valid && !(hit && !h_cls.col0) &&
                   (!h_cls.last_col || (out_count_reg < CNT_W'(OUT_DEPTH)));
    assign head_pop = issue;

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg  <= 1'b0;
            s2_v_reg  <= 1'b0;
            s3_v_reg  <= 1'b0;
            s4_v_reg  <= 1'b0;
            s5_v_reg  <= 1'b0;
            s6_v_reg  <= 1'b0;
            s7_v_reg  <= 1'b0;
            s8_v_reg  <= 1'b0;
            s9_v_reg  <= 1'b0;
            s10_v_reg <= 1'b0;
            s11_v_reg <= 1'b0;
            s12_v_reg <= 1'b0;
        end
        else
        begin
            s1_v_reg  <= issue;
            s2_v_reg  <= s1_v_reg;
            s3_v_reg  <= s2_v_reg;
            s4_v_reg  <= s3_v_reg;
            s5_v_reg  <= s4_v_reg;
            s6_v_reg  <= s5_v_reg;
            s7_v_reg  <= s6_v_reg && s6_cls_reg.last_col;
            s8_v_reg  <= s7_v_reg;
            s9_v_reg  <= s8_v_reg;
            s10_v_reg <= s9_v_reg;
            s11_v_reg <= s10_v_reg;
            s12_v_reg <= s11_v_reg;
        end
    end

    // Accumulate datapath
    always_ff @(posedge clk)
    begin
        s1_row_reg <= h_row;
        s1_cls_reg <= h_cls;
        s1_old_reg <= h_item.old_result;
        s1_raw_reg <= fp_mul_raw({h_item.matrix_elem, 16'd0}, {h_item.vector_elem, 16'd0});

        s2_row_reg <= s1_row_reg;
        s2_cls_reg <= s1_cls_reg;
        s2_old_reg <= s1_old_reg;
        s2_raw_reg <= fp_norm(s1_raw_reg);

        s3_row_reg  <= s2_row_reg;
        s3_cls_reg  <= s2_cls_reg;
        s3_old_reg  <= s2_old_reg;
        s3_prod_reg <= fp_round(s2_raw_reg);

        s4_row_reg <= s3_row_reg;
        s4_cls_reg <= s3_cls_reg;
        s4_old_reg <= s3_old_reg;
        s4_raw_reg <= fp_add_raw(s3_cls_reg.col0 ? F32_ZERO : rd_data_reg, s3_prod_reg);

        s5_row_reg <= s4_row_reg;
        s5_cls_reg <= s4_cls_reg;
        s5_old_reg <= s4_old_reg;
        s5_raw_reg <= fp_norm(s4_raw_reg);

        s6_row_reg <= s5_row_reg;
        s6_cls_reg <= s5_cls_reg;
        s6_old_reg <= s5_old_reg;
        s6_acc_reg <= fp_round(s5_raw_reg);
    end

    // Row-sum memory: read for stage 3, write from stage 6
    always_ff @(posedge clk)
    begin
        if (s2_v_reg)
        begin
            rd_data_reg <= sums_mem[s2_row_reg];
        end
        if (s6_v_reg)
        begin
            sums_mem[s6_row_reg] <= s6_acc_reg;
        end
    end

    // Scaling datapath
    always_ff @(posedge clk)
    begin
        s7_row_reg  <= s6_row_reg;
        s7_last_reg <= s6_cls_reg.last_row;
        s7_bnz_reg  <= (scale.beta[14:0] != 15'd0);
        s7_a_reg    <= fp_mul_raw({scale.alpha, 16'd0}, s6_acc_reg);
        s7_b_reg    <= fp_mul_raw({scale.beta, 16'd0}, {s6_old_reg, 16'd0});

        s8_row_reg  <= s7_row_reg;
        s8_last_reg <= s7_last_reg;
        s8_bnz_reg  <= s7_bnz_reg;
        s8_a_reg    <= fp_norm(s7_a_reg);
        s8_b_reg    <= fp_norm(s7_b_reg);

        s9_row_reg  <= s8_row_reg;
        s9_last_reg <= s8_last_reg;
        s9_bnz_reg  <= s8_bnz_reg;
        s9_t_reg    <= fp_round(s8_a_reg);
        s9_by_reg   <= fp_round(s8_b_reg);

        s10_row_reg  <= s9_row_reg;
        s10_last_reg <= s9_last_reg;
        s10_bnz_reg  <= s9_bnz_reg;
        s10_t_reg    <= s9_t_reg;
        s10_raw_reg  <= fp_add_raw(s9_t_reg, s9_by_reg);

        s11_row_reg  <= s10_row_reg;
        s11_last_reg <= s10_last_reg;
        s11_bnz_reg  <= s10_bnz_reg;
        s11_t_reg    <= s10_t_reg;
        s11_raw_reg  <= fp_norm(s10_raw_reg);

        s12_row_reg  <= s11_row_reg;
        s12_last_reg <= s11_last_reg;
        s12_bnz_reg  <= s11_bnz_reg;
        s12_t_reg    <= s11_t_reg;
        s12_raw_reg  <= s11_raw_reg;
    end

    // Final rounding into the result queue; zero beta skips the old-y term
    assign final_f32 = s12_bnz_reg ? fp_round(s12_raw_reg) : s12_t_reg;
    assign push      = s12_v_reg;
    assign push_item = '{new_result: f32_to_bf16(final_f32),
                         result_row: RESULT_ROW_W'(s12_row_reg),
                         final_row:  s12_last_reg};

    // Result credits: every issued last-column item holds a queue slot
    always_comb
    begin
        out_count_next = out_count_reg;
        if ((issue && h_cls.last_col) && !result_taken)
        begin
            out_count_next = out_count_reg + 1'b1;
        end
        else if (!(issue && h_cls.last_col) && result_taken)
        begin
            out_count_next = out_count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_count_reg <= '0;
        end
        else
        begin
            out_count_reg <= out_count_next;
        end
    end

    `BMV_ASSERT_IMP(a_push_has_credit, push, out_count_reg != '0,
        "result produced without a reserved slot")
    `BMV_ASSERT_NEVER(a_credit_bound, out_count_reg > CNT_W'(OUT_DEPTH),
        "result credits exceed queue depth")
    `BMV_ASSERT_IMP(a_sum_order, s2_v_reg && !s2_cls_reg.col0,
        !(s3_v_reg && (s3_row_reg == s2_row_reg)) &&
        !(s4_v_reg && (s4_row_reg == s2_row_reg)) &&
        !(s5_v_reg && (s5_row_reg == s2_row_reg)),
        "row sum read before its pending update")

endmodule

`default_nettype wire

### design/bf16_matrix_vector_multiply.sv
// Top level of the bf16 matrix-vector multiply, y = alpha*A*x + beta*y.
//
//   channel   ports                                  moves
//   config    wr_en, wr_index, wr_data               register write, no stall
//   input     item_valid, item_ready, item           one A element with x and old y
//   output    result_valid, result_ready, result     one finished y element
//
// One item per cycle sustained when row_count is 5 or more and result slots are
// free; the limit is the row-sum memory loop (read at stage 3, write at stage 6
// of the accumulate pipe). With fewer rows an item past column 0 waits until
// its row's previous item has left stage 4 of the accumulate pipe. The result
// queue holds 16 items and the input queue 4, so each side stalls on its own.
// Reset clears control and counters only; the row-sum memory needs no clearing.
`default_nettype none

module bf16_matrix_vector_multiply #(
    parameter int MAX_ROWS = bmv_pkg::MAX_ROWS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            wr_en,
    input  logic [bmv_pkg::CFG_INDEX_W-1:0] wr_index,
    input  logic [bmv_pkg::CFG_DATA_W-1:0]  wr_data,
    input  logic                            item_valid,
    output logic                            item_ready,
    input  bmv_pkg::in_item_t               item,
    output logic                            result_valid,
    input  logic                            result_ready,
    output bmv_pkg::out_item_t              result
);

    import bmv_pkg::*;

    localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int QW = $bits(in_item_t) + RW + $bits(item_cls_t);
    localparam int OW = $bits(out_item_t);

    logic          q_push, q_full, q_valid, q_pop;
    logic [QW-1:0] q_wdata, q_rdata;
    scale_t        scale;
    logic          o_push, o_full, o_pop;
    out_item_t     o_item;
    logic [OW-1:0] o_rdata;

    // Front end
    bmv_front #(
        .MAX_ROWS (MAX_ROWS),
        .RW       (RW),
        .QW       (QW)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (wr_en),
        .wr_index   (wr_index),
        .wr_data    (wr_data),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .q_push     (q_push),
        .q_data     (q_wdata),
        .q_full     (q_full),
        .scale      (scale)
    );

    // Classified item queue
    bmv_fifo #(
        .WIDTH (QW),
        .DEPTH (ITEM_Q_DEPTH)
    ) u_item_q (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_wdata),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .data      (q_rdata)
    );

    // Back end
    bmv_back #(
        .MAX_ROWS (MAX_ROWS),
        .RW       (RW),
        .QW       (QW)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (q_valid),
        .head_data    (q_rdata),
        .head_pop     (q_pop),
        .scale        (scale),
        .push         (o_push),
        .push_item    (o_item),
        .result_taken (o_pop)
    );

    // Result queue
    bmv_fifo #(
        .WIDTH (OW),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (o_push),
        .push_data (o_item),
        .full      (o_full),
        .pop       (o_pop),
        .valid     (result_valid),
        .data      (o_rdata)
    );

    assign o_pop  = result_valid && result_ready;
    assign result = out_item_t'(o_rdata);

    `include "bf16_matrix_vector_multiply_assert.svh"

    `BMV_ASSERT_NEVER(a_out_room, o_push && o_full, "result queue overrun")

endmodule

`default_nettype wire
